[src/dhbd_pkg.sv]
// Shared types and constants for the detection head box decode block.
package dhbd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [6:0]  class_id;
        logic [15:0] confidence;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_width;
        logic [15:0] box_height;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } q_stat_t;

endpackage

[src/detection_head_box_decode_top.sv]
// Top level of the detection head box decode block: APB registers, front, queue, back.
// Takes one transaction per cycle while in_ready is high, class scores and threshold writes
// alike. After its last class score, an anchor's result passes through one front register
// behind the threshold RAM read, the queue, a multiply stage and a clip stage that is the
// output register. in_ready drops only when the four-entry queue between front and back is
// close to full, which happens when out_ready is held low. The threshold table needs no
// clearing pass: each entry has a valid bit cleared at reset and an unwritten entry reads as
// zero. Thresholds for classes at or above MAX_CLASSES are discarded.
module detection_head_box_decode_top #(
    parameter int MAX_CLASSES = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [15:0]        score,
    input  logic               last_class,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic signed [15:0] box_width,
    input  logic signed [15:0] box_height,
    input  logic [6:0]         threshold_class,
    input  logic [15:0]        threshold_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         class_id,
    output logic [15:0]        left,
    output logic [15:0]        top,
    output logic [16:0]        width_px,
    output logic [16:0]        height_px,
    output logic [15:0]        confidence
);
    import dhbd_pkg::*;

    localparam logic REG_NET_WIDTH  = 1'b0;
    localparam logic REG_NET_HEIGHT = 1'b1;

    logic [12:0] net_width_reg, net_width_next;
    logic [12:0] net_height_reg, net_height_next;
    logic        cfg_wr;

    q_stat_t     q_stat;
    q_entry_t    q_entry, q_head;
    logic        q_push, q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        net_width_next  = net_width_reg;
        net_height_next = net_height_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_NET_WIDTH:  net_width_next  = pwdata[12:0];
                REG_NET_HEIGHT: net_height_next = pwdata[12:0];
                default:        net_width_next  = net_width_reg;
            endcase
        end
        prdata = (paddr[2] == REG_NET_HEIGHT) ? {19'b0, net_height_reg} : {19'b0, net_width_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_width_reg  <= 13'd640;
            net_height_reg <= 13'd640;
        end
        else
        begin
            net_width_reg  <= net_width_next;
            net_height_reg <= net_height_next;
        end
    end

    dhbd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .score          (score),
        .last_class     (last_class),
        .center_x       (center_x),
        .center_y       (center_y),
        .box_width      (box_width),
        .box_height     (box_height),
        .threshold_class(threshold_class),
        .threshold_value(threshold_value),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    dhbd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_entry),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    dhbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .net_width (net_width_reg),
        .net_height(net_height_reg),
        .q_stat    (q_stat),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .class_id  (class_id),
        .left      (left),
        .top       (top),
        .width_px  (width_px),
        .height_px (height_px),
        .confidence(confidence)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_push_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $past(in_valid && in_ready && !action && last_class))
        else $error("queue push without a last class transaction");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !q_pop)
        else $error("queue pop while empty");

endmodule

[src/dhbd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module dhbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[src/dhbd_front.sv]
// Front part: accepts transactions, tracks the per-anchor argmax, holds thresholds, filters.
module dhbd_front #(
    parameter int MAX_CLASSES = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [15:0]        score,
    input  logic               last_class,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic signed [15:0] box_width,
    input  logic signed [15:0] box_height,
    input  logic [6:0]         threshold_class,
    input  logic [15:0]        threshold_value,
    input  dhbd_pkg::q_stat_t  q_stat,
    output logic               q_push,
    output dhbd_pkg::q_entry_t q_entry
);
    import dhbd_pkg::*;

    localparam int TBL_DEPTH = (MAX_CLASSES > 128) ? 128 : MAX_CLASSES;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam logic [6:0] COUNTER_LIMIT = (MAX_CLASSES > 128) ? 7'd127 : 7'(MAX_CLASSES - 1);

    logic [15:0] best_score_reg, best_score_next;
    logic [6:0]  best_class_reg, best_class_next;
    logic [6:0]  counter_reg, counter_next;
    logic [TBL_DEPTH-1:0] tvalid_reg, tvalid_next;
    logic        s1_valid_reg, s1_valid_next;
    logic [6:0]  s1_class_reg;
    logic [15:0] s1_score_reg;
    logic [15:0] s1_cx_reg, s1_cy_reg, s1_bw_reg, s1_bh_reg;
    logic        s1_tv_reg;

    logic        accept, score_acc, thr_wr, win;
    logic [6:0]  fin_class;
    logic [15:0] fin_score;
    logic [15:0] thr_rdata, thr;

    assign in_ready  = !q_stat.full && !(s1_valid_reg && q_stat.one_left);
    assign accept    = in_valid && in_ready;
    assign score_acc = accept && !action;
    assign thr_wr    = accept && action && (int'(threshold_class) < MAX_CLASSES);
    assign win       = score > best_score_reg;
    assign fin_class = win ? counter_reg : best_class_reg;
    assign fin_score = win ? score : best_score_reg;

    always_comb
    begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        counter_next    = counter_reg;
        tvalid_next     = tvalid_reg;
        s1_valid_next   = score_acc && last_class;
        if (score_acc)
        begin
            if (last_class)
            begin
                best_score_next = '0;
                best_class_next = '0;
                counter_next    = '0;
            end
            else
            begin
                best_score_next = fin_score;
                best_class_next = fin_class;
                if (counter_reg < COUNTER_LIMIT)
                begin
                    counter_next = counter_reg + 7'd1;
                end
            end
        end
        if (thr_wr)
        begin
            tvalid_next[threshold_class[TBL_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            counter_reg    <= '0;
            tvalid_reg     <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            counter_reg    <= counter_next;
            tvalid_reg     <= tvalid_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_next)
        begin
            s1_class_reg <= fin_class;
            s1_score_reg <= fin_score;
            s1_cx_reg    <= center_x;
            s1_cy_reg    <= center_y;
            s1_bw_reg    <= box_width;
            s1_bh_reg    <= box_height;
            s1_tv_reg    <= tvalid_reg[fin_class[TBL_AW-1:0]];
        end
    end

    dhbd_ram #(
        .WIDTH(16),
        .DEPTH(TBL_DEPTH)
    ) u_thr_ram (
        .clk  (clk),
        .we   (thr_wr),
        .waddr(threshold_class[TBL_AW-1:0]),
        .wdata(threshold_value),
        .re   (s1_valid_next),
        .raddr(fin_class[TBL_AW-1:0]),
        .rdata(thr_rdata)
    );

    // unwritten entries read as zero
    assign thr    = s1_tv_reg ? thr_rdata : 16'd0;
    assign q_push = s1_valid_reg && !(s1_score_reg < thr);

    always_comb
    begin
        q_entry.class_id   = s1_class_reg;
        q_entry.confidence = s1_score_reg;
        q_entry.center_x   = s1_cx_reg;
        q_entry.center_y   = s1_cy_reg;
        q_entry.box_width  = s1_bw_reg;
        q_entry.box_height = s1_bh_reg;
    end

endmodule

[src/dhbd_queue.sv]
// Short queue of kept anchors between the front and back parts.
module dhbd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dhbd_pkg::q_entry_t push_data,
    input  logic               pop,
    output dhbd_pkg::q_entry_t head,
    output dhbd_pkg::q_stat_t  stat
);
    import dhbd_pkg::*;

    q_entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head          = mem_reg[rd_ptr_reg];
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.one_left = (count_reg == (QAW+1)'(QDEPTH - 1));

endmodule

[src/dhbd_back.sv]
// Back part: box scaling multiplies, then truncation and clipping into the output register.
module dhbd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [12:0]        net_width,
    input  logic [12:0]        net_height,
    input  dhbd_pkg::q_stat_t  q_stat,
    input  dhbd_pkg::q_entry_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         class_id,
    output logic [15:0]        left,
    output logic [15:0]        top,
    output logic [16:0]        width_px,
    output logic [16:0]        height_px,
    output logic [15:0]        confidence
);
    import dhbd_pkg::*;

    logic               m_valid_reg, m_valid_next;
    logic [6:0]         m_class_reg;
    logic [15:0]        m_conf_reg;
    logic signed [31:0] m_pl_reg, m_pt_reg;
    logic signed [29:0] m_pw_reg, m_ph_reg;
    logic               o_valid_reg, o_valid_next;

    logic               o_adv, m_adv;
    logic signed [17:0] dx, dy;
    logic signed [13:0] ws, hs;
    logic signed [31:0] pl, pt;
    logic signed [29:0] pw, ph;
    logic [15:0]        left_next, top_next;
    logic [16:0]        wpx_next, hpx_next;

    function automatic logic [15:0] clip_corner(logic signed [31:0] p, logic [12:0] sz);
        logic [20:0] q;
        logic [20:0] hi;
        logic [20:0] v;
        q  = p[31:11];
        hi = {4'b0, sz - 13'd1, 4'b0};
        v  = (q > hi) ? hi : q;
        if (p <= 0)
        begin
            v = '0;
        end
        if (v > 21'd65535)
        begin
            v = 21'd65535;
        end
        return v[15:0];
    endfunction

    function automatic logic [16:0] clip_size(logic signed [29:0] p, logic [12:0] sz);
        logic [19:0] q;
        logic [19:0] hi;
        logic [19:0] v;
        q  = p[29:10];
        hi = {3'b0, sz, 4'b0};
        v  = (q > hi) ? hi : q;
        if (p <= 0)
        begin
            v = '0;
        end
        return v[16:0];
    endfunction

    assign o_adv = !o_valid_reg || out_ready;
    assign m_adv = !m_valid_reg || o_adv;
    assign q_pop = !q_stat.empty && m_adv;

    // corner in Q.15: 2*center - size
    assign dx = {q_head.center_x[15], q_head.center_x, 1'b0}
              - {{2{q_head.box_width[15]}}, q_head.box_width};
    assign dy = {q_head.center_y[15], q_head.center_y, 1'b0}
              - {{2{q_head.box_height[15]}}, q_head.box_height};
    assign ws = $signed({1'b0, net_width});
    assign hs = $signed({1'b0, net_height});
    assign pl = 32'(dx) * 32'(ws);
    assign pt = 32'(dy) * 32'(hs);
    assign pw = 30'($signed(q_head.box_width)) * 30'(ws);
    assign ph = 30'($signed(q_head.box_height)) * 30'(hs);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        o_valid_next = o_valid_reg;
        if (m_adv)
        begin
            m_valid_next = !q_stat.empty;
        end
        if (o_adv)
        begin
            o_valid_next = m_valid_reg;
        end
        left_next = clip_corner(m_pl_reg, net_width);
        top_next  = clip_corner(m_pt_reg, net_height);
        wpx_next  = clip_size(m_pw_reg, net_width);
        hpx_next  = clip_size(m_ph_reg, net_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_class_reg <= q_head.class_id;
            m_conf_reg  <= q_head.confidence;
            m_pl_reg    <= pl;
            m_pt_reg    <= pt;
            m_pw_reg    <= pw;
            m_ph_reg    <= ph;
        end
        if (o_adv && m_valid_reg)
        begin
            class_id   <= m_class_reg;
            confidence <= m_conf_reg;
            left       <= left_next;
            top        <= top_next;
            width_px   <= wpx_next;
            height_px  <= hpx_next;
        end
    end

    assign out_valid = o_valid_reg;

endmodule
